[src/pbc_pkg.sv]
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants shared by the peaking biquad and compressor block.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 18;
  localparam int ThrW    = 15;
  localparam int InvW    = 16;
  localparam int YW      = 20;
  localparam int OpndW   = 21;
  localparam int ProdW   = CoefW + OpndW;
  localparam int AccW    = 42;
  localparam int MagW    = 21;
  localparam int CfgIdxW = 3;
  localparam int TapW    = 3;
  localparam int RndSh   = 14;
  localparam int CmpSh   = 16;

  localparam logic [TapW-1:0] TapLast = TapW'(4);
  localparam logic [TapW-1:0] TapFb1  = TapW'(3);

  localparam logic [CfgIdxW-1:0] CfgFf0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFf1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgFf2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgFb1 = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgFb2 = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgThr = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] CfgInv = CfgIdxW'(6);

  localparam logic signed [CoefW-1:0] Ff0Reset = CoefW'(16384);
  localparam logic [ThrW-1:0]         ThrReset = ThrW'(32767);
  localparam logic [InvW-1:0]         InvReset = InvW'(65535);

  localparam logic signed [AccW-1:0] RndY    = AccW'(8192);
  localparam logic signed [AccW-1:0] RndC    = AccW'(32768);
  localparam logic signed [AccW-1:0] YMaxAcc = AccW'(524287);
  localparam logic signed [AccW-1:0] YMinAcc = -AccW'(524288);

  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StLast,
    StRound,
    StCmul,
    StCacc,
    StFin
  } state_e;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

endpackage

[src/pbc_in_if.sv]
// ----------------------------------------------------------------------------
// pbc_in_if
// Input channel: one audio sample and its block-start flag per item.
// ----------------------------------------------------------------------------
interface pbc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbc_pkg::SampleW-1:0]  sample_in;
  logic                                block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

[src/pbc_out_if.sv]
// ----------------------------------------------------------------------------
// pbc_out_if
// Output channel: one compressed sample and its compression flag per item.
// ----------------------------------------------------------------------------
interface pbc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbc_pkg::SampleW-1:0]  sample_out;
  logic                                was_compressed;

  modport source (output valid, output sample_out, output was_compressed, input ready);
  modport sink   (input valid, input sample_out, input was_compressed, output ready);
endinterface

[src/pbc_mac.sv]
// ----------------------------------------------------------------------------
// pbc_mac
// Shared multiply-accumulate unit with a registered product stage.
// ----------------------------------------------------------------------------
module pbc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pbc_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [pbc_pkg::CoefW-1:0]   coef_i,
  input  logic signed [pbc_pkg::OpndW-1:0]   opnd_i,
  output logic signed [pbc_pkg::AccW-1:0]    acc_o
);

  logic signed [pbc_pkg::ProdW-1:0] prod_q;
  logic                             prod_sub_q;
  logic signed [pbc_pkg::AccW-1:0]  acc_q;
  logic signed [pbc_pkg::AccW-1:0]  prod_ext;

  assign prod_ext = pbc_pkg::AccW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_sub_q <= 1'b0;
    end else if (ctrl_i.mul_en) begin
      prod_sub_q <= ctrl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= pbc_pkg::ProdW'(coef_i * opnd_i);
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= prod_sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  assign acc_o = acc_q;

endmodule

[src/peaking_biquad_with_compressor_unit.sv]
// ----------------------------------------------------------------------------
// peaking_biquad_with_compressor_unit
// Direct-form-I biquad peaking filter followed by a hard-knee compressor.
// ----------------------------------------------------------------------------
// Each item passes through the sequencer states in order after acceptance:
// five filter-tap multiplies through the single shared multiply-accumulate
// unit, a drain of its product register, a round-and-saturate step, and
// three compressor steps, which reuse the same multiplier for the excess
// times the inverse ratio, before its result is loaded into the output
// register. The next item is accepted once the sequencer is back in its
// idle state, even while the previous result still waits in the output
// register, so a new item is taken only after the last one is loaded there,
// and is held off longer while the output register stays full. Setting
// block_start clears the filter history before that item is filtered.
module peaking_biquad_with_compressor_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pbc_in_if.sink                               in_ch,
  pbc_out_if.source                            out_ch,
  input  logic                                 cfg_we_i,
  input  logic [pbc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [pbc_pkg::CoefW-1:0]            cfg_wdata_i
);

  pbc_pkg::state_e state_q, state_d;
  logic [pbc_pkg::TapW-1:0] tap_q, tap_d;

  logic signed [pbc_pkg::CoefW-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  logic [pbc_pkg::ThrW-1:0]         thr_q;
  logic [pbc_pkg::InvW-1:0]         inv_q;

  logic signed [pbc_pkg::SampleW-1:0] x0_q, in_h1_q, in_h2_q;
  logic signed [pbc_pkg::YW-1:0]      out_h1_q, out_h2_q, y_q, y_d;
  logic [pbc_pkg::MagW-1:0]           mag_q, mag_d, excess;
  logic                               neg_q, flag_q, flag_d;

  logic                               out_vld_q, out_vld_d;
  logic signed [pbc_pkg::SampleW-1:0] out_smp_q, out_smp_d;
  logic                               out_cmp_q;

  pbc_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [pbc_pkg::CoefW-1:0]   mac_coef;
  logic signed [pbc_pkg::OpndW-1:0]   mac_opnd;
  logic signed [pbc_pkg::AccW-1:0]    acc;

  logic ld_x, upd_hist, ld_cmp, ld_out;

  logic signed [pbc_pkg::AccW-1:0]    rnd_sum, rnd_shf, sc_sum;
  logic signed [pbc_pkg::MagW-1:0]    y_ext;
  logic [pbc_pkg::MagW-1:0]           scaled;
  logic [pbc_pkg::MagW:0]             mag2;

  pbc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .acc_o  (acc)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q <= pbc_pkg::Ff0Reset;
      ff1_q <= '0;
      ff2_q <= '0;
      fb1_q <= '0;
      fb2_q <= '0;
      thr_q <= pbc_pkg::ThrReset;
      inv_q <= pbc_pkg::InvReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbc_pkg::CfgFf0: ff0_q <= cfg_wdata_i;
        pbc_pkg::CfgFf1: ff1_q <= cfg_wdata_i;
        pbc_pkg::CfgFf2: ff2_q <= cfg_wdata_i;
        pbc_pkg::CfgFb1: fb1_q <= cfg_wdata_i;
        pbc_pkg::CfgFb2: fb2_q <= cfg_wdata_i;
        pbc_pkg::CfgThr: thr_q <= cfg_wdata_i[pbc_pkg::ThrW-1:0];
        pbc_pkg::CfgInv: inv_q <= cfg_wdata_i[pbc_pkg::InvW-1:0];
        default: ;
      endcase
    end
  end

  // Round the filter sum to Q.15 and saturate it to 20 bits.
  always_comb begin
    rnd_sum = acc + pbc_pkg::RndY;
    rnd_shf = rnd_sum >>> pbc_pkg::RndSh;
    if (rnd_shf > pbc_pkg::YMaxAcc) begin
      y_d = pbc_pkg::YW'(pbc_pkg::YMaxAcc);
    end else if (rnd_shf < pbc_pkg::YMinAcc) begin
      y_d = pbc_pkg::YW'(pbc_pkg::YMinAcc);
    end else begin
      y_d = rnd_shf[pbc_pkg::YW-1:0];
    end
  end

  // Magnitude, excess over the threshold, and the compression decision.
  always_comb begin
    y_ext  = pbc_pkg::MagW'(y_q);
    mag_d  = y_q[pbc_pkg::YW-1] ? pbc_pkg::MagW'(-y_ext) : pbc_pkg::MagW'(y_ext);
    flag_d = mag_d > pbc_pkg::MagW'(thr_q);
    excess = mag_d - pbc_pkg::MagW'(thr_q);
  end

  // Apply the scaled excess, restore the sign and saturate to 16 bits.
  always_comb begin
    sc_sum = acc + pbc_pkg::RndC;
    scaled = sc_sum[pbc_pkg::CmpSh +: pbc_pkg::MagW];
    mag2   = flag_q ? ((pbc_pkg::MagW+1)'(thr_q) + (pbc_pkg::MagW+1)'(scaled))
                    : (pbc_pkg::MagW+1)'(mag_q);
    if (neg_q) begin
      if (mag2 >= (pbc_pkg::MagW+1)'(32768)) begin
        out_smp_d = pbc_pkg::SampleW'(-32768);
      end else begin
        out_smp_d = pbc_pkg::SampleW'(-$signed(mag2));
      end
    end else begin
      if (mag2 > (pbc_pkg::MagW+1)'(32767)) begin
        out_smp_d = pbc_pkg::SampleW'(32767);
      end else begin
        out_smp_d = pbc_pkg::SampleW'(mag2);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    mac_ctrl  = '0;
    mac_coef  = ff0_q;
    mac_opnd  = pbc_pkg::OpndW'(x0_q);
    ld_x      = 1'b0;
    upd_hist  = 1'b0;
    ld_cmp    = 1'b0;
    ld_out    = 1'b0;
    in_ch.ready = 1'b0;

    case (tap_q)
      3'd0: begin
        mac_coef = ff0_q;
        mac_opnd = pbc_pkg::OpndW'(x0_q);
      end
      3'd1: begin
        mac_coef = ff1_q;
        mac_opnd = pbc_pkg::OpndW'(in_h1_q);
      end
      3'd2: begin
        mac_coef = ff2_q;
        mac_opnd = pbc_pkg::OpndW'(in_h2_q);
      end
      3'd3: begin
        mac_coef = fb1_q;
        mac_opnd = pbc_pkg::OpndW'(out_h1_q);
      end
      3'd4: begin
        mac_coef = fb2_q;
        mac_opnd = pbc_pkg::OpndW'(out_h2_q);
      end
      default: ;
    endcase

    case (state_q)
      pbc_pkg::StIdle: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ld_x         = 1'b1;
          mac_ctrl.clr = 1'b1;
          tap_d        = '0;
          state_d      = pbc_pkg::StMac;
        end
      end
      pbc_pkg::StMac: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sub    = tap_q >= pbc_pkg::TapFb1;
        mac_ctrl.acc_en = tap_q != '0;
        if (tap_q == pbc_pkg::TapLast) begin
          state_d = pbc_pkg::StLast;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      pbc_pkg::StLast: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = pbc_pkg::StRound;
      end
      pbc_pkg::StRound: begin
        upd_hist = 1'b1;
        state_d  = pbc_pkg::StCmul;
      end
      pbc_pkg::StCmul: begin
        mac_ctrl.clr    = 1'b1;
        mac_ctrl.mul_en = 1'b1;
        mac_coef        = pbc_pkg::CoefW'(inv_q);
        mac_opnd        = $signed(excess);
        ld_cmp          = 1'b1;
        state_d         = pbc_pkg::StCacc;
      end
      pbc_pkg::StCacc: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = pbc_pkg::StFin;
      end
      pbc_pkg::StFin: begin
        if (!out_vld_q || out_ch.ready) begin
          ld_out  = 1'b1;
          state_d = pbc_pkg::StIdle;
        end
      end
      default: state_d = pbc_pkg::StIdle;
    endcase

    if (ld_out) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pbc_pkg::StIdle;
      tap_q     <= '0;
      out_vld_q <= 1'b0;
      in_h1_q   <= '0;
      in_h2_q   <= '0;
      out_h1_q  <= '0;
      out_h2_q  <= '0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      out_vld_q <= out_vld_d;
      if (ld_x && in_ch.block_start) begin
        in_h1_q  <= '0;
        in_h2_q  <= '0;
        out_h1_q <= '0;
        out_h2_q <= '0;
      end else if (upd_hist) begin
        in_h2_q  <= in_h1_q;
        in_h1_q  <= x0_q;
        out_h2_q <= out_h1_q;
        out_h1_q <= y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_x) begin
      x0_q <= in_ch.sample_in;
    end
    if (upd_hist) begin
      y_q <= y_d;
    end
    if (ld_cmp) begin
      mag_q  <= mag_d;
      flag_q <= flag_d;
      neg_q  <= y_q[pbc_pkg::YW-1];
    end
    if (ld_out) begin
      out_smp_q <= out_smp_d;
      out_cmp_q <= flag_q;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.sample_out     = out_smp_q;
  assign out_ch.was_compressed = out_cmp_q;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams audio samples through the peaking biquad and compressor block and
// compares every output item with a cycle-free model of the filter and the
// compressor, across directed corner settings and random coefficient sets.
// ----------------------------------------------------------------------------
module testbench;
  import pbc_pkg::*;

  localparam int NumRegs       = 7;
  localparam int RandPhases    = 16;
  localparam int ItemsPerPhase = 50;
  localparam int SettleCycles  = 16;
  localparam int LongHold      = 200;
  localparam int StuckLimit    = 2000;

  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(7);

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
  localparam logic [CoefW-1:0] CoefMax   = 18'h1FFFF;
  localparam logic [CoefW-1:0] CoefMin   = 18'h20000;
  localparam logic [CoefW-1:0] CoefUnity = 18'd16384;
  localparam logic [CoefW-1:0] AllOnes   = 18'h3FFFF;

  localparam longint YMax   = 524287;
  localparam longint YMin   = -524288;
  localparam longint OutMax = 32767;
  localparam longint OutMin = -32768;

  typedef struct {
    logic signed [SampleW-1:0] sample_in;
    logic                      block_start;
  } pcm_item_t;

  typedef struct {
    logic signed [SampleW-1:0] sample_out;
    logic                      was_compressed;
  } pcm_result_t;

  typedef logic [CoefW-1:0] cfg_vals_t [NumRegs];

  typedef enum int {RxAlways, RxHalf, RxSparse, RxPattern} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoefW-1:0]   cfg_wdata_i;

  pbc_in_if  pcm_in ();
  pbc_out_if pcm_out ();

  peaking_biquad_with_compressor_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (pcm_in),
    .out_ch     (pcm_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [CoefW-1:0] k_ff0 = Ff0Reset;
  logic signed [CoefW-1:0] k_ff1 = '0;
  logic signed [CoefW-1:0] k_ff2 = '0;
  logic signed [CoefW-1:0] k_fb1 = '0;
  logic signed [CoefW-1:0] k_fb2 = '0;
  logic [ThrW-1:0]         k_thr = ThrReset;
  logic [InvW-1:0]         k_inv = InvReset;

  logic signed [SampleW-1:0] x_d1 = '0;
  logic signed [SampleW-1:0] x_d2 = '0;
  logic signed [YW-1:0]      y_d1 = '0;
  logic signed [YW-1:0]      y_d2 = '0;

  pcm_item_t   pending_pcm[$];
  pcm_result_t expected_pcm[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;

  function automatic pcm_result_t filter_and_compress(input logic signed [SampleW-1:0] x,
                                                      input logic blk);
    pcm_result_t r;
    longint acc, y, mag, excess, res;
    if (blk) begin
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
    end
    acc = longint'(k_ff0) * longint'(x) + longint'(k_ff1) * longint'(x_d1)
        + longint'(k_ff2) * longint'(x_d2) - longint'(k_fb1) * longint'(y_d1)
        - longint'(k_fb2) * longint'(y_d2);
    y = (acc + 8192) >>> 14;
    if (y > YMax) y = YMax;
    if (y < YMin) y = YMin;
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = YW'(y);
    mag = (y < 0) ? -y : y;
    r.was_compressed = 1'b0;
    if (mag > longint'(k_thr)) begin
      excess = mag - longint'(k_thr);
      mag = longint'(k_thr) + ((excess * longint'(k_inv) + 32768) >>> 16);
      r.was_compressed = 1'b1;
    end
    res = (y < 0) ? -mag : mag;
    if (res > OutMax) res = OutMax;
    if (res < OutMin) res = OutMin;
    r.sample_out = SampleW'(res);
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return SampleMax;
      1: return SampleMin;
      2: return '0;
      3, 4: return SampleW'(int'($urandom_range(0, 4000)) - 2000);
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic cfg_vals_t unity_settings(input logic [CoefW-1:0] thr,
                                               input logic [CoefW-1:0] inv);
    cfg_vals_t v;
    v[CfgFf0] = CoefUnity;
    v[CfgFf1] = '0;
    v[CfgFf2] = '0;
    v[CfgFb1] = '0;
    v[CfgFb2] = '0;
    v[CfgThr] = thr;
    v[CfgInv] = inv;
    return v;
  endfunction

  function automatic cfg_vals_t random_settings();
    cfg_vals_t v;
    int a1, a2, lim;
    if ($urandom_range(0, 3) == 0) begin
      // Arbitrary coefficients, often unstable, with the extremes mixed in.
      foreach (v[i]) begin
        case ($urandom_range(0, 3))
          0: v[i] = CoefMax;
          1: v[i] = CoefMin;
          default: v[i] = CoefW'($urandom);
        endcase
      end
    end else begin
      // A stable section keeps the history meaningful over long runs.
      a2  = int'($urandom_range(0, 29000)) - 14500;
      lim = 16384 + a2 - 1;
      a1  = int'($urandom_range(0, 2 * lim)) - lim;
      v[CfgFf0] = CoefW'($urandom_range(8000, 40000));
      v[CfgFf1] = CoefW'(a1);
      v[CfgFf2] = CoefW'(int'($urandom_range(0, 40000)) - 20000);
      v[CfgFb1] = CoefW'(a1);
      v[CfgFb2] = CoefW'(a2);
    end
    case ($urandom_range(0, 3))
      0: v[CfgThr] = '0;
      1: v[CfgThr] = AllOnes;
      default: v[CfgThr] = CoefW'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: v[CfgInv] = '0;
      1: v[CfgInv] = AllOnes;
      default: v[CfgInv] = CoefW'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgFf0: k_ff0 = data;
      CfgFf1: k_ff1 = data;
      CfgFf2: k_ff2 = data;
      CfgFb1: k_fb1 = data;
      CfgFb2: k_fb2 = data;
      CfgThr: k_thr = data[ThrW-1:0];
      CfgInv: k_inv = data[InvW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_vals_t v, input bit poke_unused);
    for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), v[i]);
    if (poke_unused) write_reg(CfgUnused, CoefW'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_item(input logic signed [SampleW-1:0] s, input logic blk);
    pcm_item_t it;
    it.sample_in   = s;
    it.block_start = blk;
    pending_pcm.push_back(it);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_pcm.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : drive
    pcm_item_t nxt;
    bit fire;
    if (!rst_ni) begin
      pcm_in.valid       <= 1'b0;
      pcm_in.sample_in   <= '0;
      pcm_in.block_start <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      fire = pcm_in.valid && pcm_in.ready;
      if (fire) begin
        expected_pcm.push_back(filter_and_compress(pcm_in.sample_in, pcm_in.block_start));
        n_accepted++;
      end
      if (!pcm_in.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          pcm_in.valid <= 1'b0;
        end else if (pending_pcm.size() > 0) begin
          nxt = pending_pcm.pop_front();
          pcm_in.valid       <= 1'b1;
          pcm_in.sample_in   <= nxt.sample_in;
          pcm_in.block_start <= nxt.block_start;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          end
        end else begin
          pcm_in.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall patterns that change every segment, plus long hold-offs.
  rx_mode_e    rx_mode;
  int          seg_left;
  int          hold_left;
  int          next_hold_at;
  logic [31:0] stall_pat;

  always @(posedge clk_i or negedge rst_ni) begin : receive
    logic rdy;
    if (!rst_ni) begin
      pcm_out.ready <= 1'b0;
      rx_mode      = RxAlways;
      seg_left     = 0;
      hold_left    = 0;
      next_hold_at = 300;
      stall_pat    = '0;
    end else if (hold_left > 0) begin
      hold_left--;
      pcm_out.ready <= 1'b0;
    end else if (n_results >= next_hold_at) begin
      hold_left = LongHold;
      next_hold_at += 400;
      pcm_out.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(16, 160);
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        stall_pat = $urandom;
      end else begin
        seg_left--;
      end
      case (rx_mode)
        RxAlways: rdy = 1'b1;
        RxHalf:   rdy = 1'($urandom_range(0, 1));
        RxSparse: rdy = ($urandom_range(0, 3) == 0);
        default: begin
          rdy = stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[31:1]};
        end
      endcase
      pcm_out.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin : check
    pcm_result_t want;
    if (rst_ni && pcm_out.valid && pcm_out.ready) begin
      n_results++;
      if (expected_pcm.size() == 0) begin
        $error("unexpected item: sample_out %0d, was_compressed %0b",
               pcm_out.sample_out, pcm_out.was_compressed);
        n_errors++;
      end else begin
        want = expected_pcm.pop_front();
        if (pcm_out.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, pcm_out.sample_out);
          n_errors++;
        end
        if (pcm_out.was_compressed !== want.was_compressed) begin
          $error("was_compressed: expected %0b, got %0b",
                 want.was_compressed, pcm_out.was_compressed);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (pcm_in.valid && pcm_in.ready) || (pcm_out.valid && pcm_out.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_vals_t s;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings pass samples through; full-scale negative is compressed.
    queue_item('0, 1'b1);
    queue_item(SampleMax, 1'b0);
    queue_item(SampleMin, 1'b0);
    queue_item(16'sd1, 1'b0);
    queue_item(-16'sd1, 1'b1);
    wait_drained();

    // Magnitudes at and just above the threshold, plus an ignored write.
    s = unity_settings(18'd1000, 18'h08000);
    load_settings(s, 1'b1);
    queue_item(16'sd1000, 1'b0);
    queue_item(-16'sd1000, 1'b0);
    queue_item(16'sd1001, 1'b0);
    queue_item(-16'sd1001, 1'b0);
    queue_item(SampleMax, 1'b0);
    queue_item(SampleMin, 1'b0);
    wait_drained();

    // Zero threshold and zero inverse ratio clamp every nonzero sample.
    s = unity_settings('0, '0);
    load_settings(s, 1'b0);
    queue_item('0, 1'b0);
    queue_item(16'sd5, 1'b0);
    queue_item(-16'sd5, 1'b0);
    queue_item(SampleMax, 1'b0);
    wait_drained();

    // Maximum feed-forward gain saturates the filter and then the output.
    s = unity_settings(18'd20000, AllOnes);
    s[CfgFf0] = CoefMax;
    s[CfgFf1] = CoefMax;
    s[CfgFf2] = CoefMax;
    load_settings(s, 1'b0);
    queue_item(SampleMax, 1'b1);
    queue_item(SampleMax, 1'b0);
    queue_item(SampleMax, 1'b0);
    queue_item(SampleMin, 1'b1);
    queue_item(SampleMin, 1'b0);
    queue_item(SampleMin, 1'b0);
    wait_drained();

    // Extreme feedback coefficients make the history run away.
    s = unity_settings('0, '0);
    s[CfgFb1] = CoefMin;
    s[CfgFb2] = CoefMax;
    load_settings(s, 1'b0);
    queue_item(16'sd1000, 1'b1);
    queue_item('0, 1'b0);
    queue_item('0, 1'b0);
    queue_item('0, 1'b0);
    wait_drained();

    for (int p = 0; p < RandPhases; p++) begin
      load_settings(random_settings(), $urandom_range(0, 3) == 0);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        queue_item(random_sample(), $urandom_range(0, 15) == 0);
      end
      wait_drained();
    end

    if (n_errors == 0 && expected_pcm.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/pbc_pkg.sv
src/pbc_in_if.sv
src/pbc_out_if.sv
src/pbc_mac.sv
src/peaking_biquad_with_compressor_unit.sv
tb/sv/testbench.sv
